FILE: hdl/assert_macros.svh
// Assertion macros shared by the walker RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is masked while reset is asserted.
`define PGTW_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pgtw: check failed");

// Check that holds at every edge, reset included.
`define PGTW_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pgtw: check failed");

`endif

FILE: hdl/pgtw_pkg.sv
// Types and constants for the four-level page table walker.
// No dependencies; imported by every walker module.
package pgtw_pkg;

  localparam int AddrW   = 48;
  localparam int DescW   = 64;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // Input item kinds
  localparam logic REQ_TRANSLATE = 1'b0;
  localparam logic REQ_RESPONSE  = 1'b1;
  // Result item kinds
  localparam logic RES_READ = 1'b0;
  localparam logic RES_DONE = 1'b1;
  // Mapping sizes
  localparam logic [1:0] SIZE_4K = 2'd0;
  localparam logic [1:0] SIZE_2M = 2'd1;
  localparam logic [1:0] SIZE_1G = 2'd2;
  // Descriptor bits
  localparam int DSC_VALID_BIT = 0;
  localparam int DSC_TABLE_BIT = 1;

  typedef enum logic {
    CFG_LOW_BASE  = 1'b0,
    CFG_HIGH_BASE = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_WALK       = 2'd0,
    CMD_BASE_FAULT = 2'd1,
    CMD_DESC       = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    logic             req_type;
    logic [AddrW-1:0] virt_addr;
    logic [DescW-1:0] read_data;
  } pgtw_in_t;

  typedef struct packed {
    logic             res_type;
    logic [AddrW-1:0] mem_addr;
    logic [AddrW-1:0] phys_addr;
    logic             fault;
    logic [1:0]       mapping_size;
  } pgtw_out_t;

  // Queue entry: data holds the level 0 descriptor address for a walk,
  // or the raw descriptor for a response.
  typedef struct packed {
    cmd_kind_e        kind;
    logic [AddrW-1:0] vaddr;
    logic [DescW-1:0] data;
  } pgtw_cmd_t;

  // Table/output address mask: bits below the physical width, page offset cleared.
  function automatic logic [AddrW-1:0] pa_mask(int phys_bits);
    int eff;
    eff = (phys_bits < AddrW) ? phys_bits : AddrW;
    return ({AddrW{1'b1}} >> (AddrW - eff)) & ~AddrW'(12'hFFF);
  endfunction

endpackage

FILE: hdl/pgtw_front.sv
// Front end: classifies input items and forms the level 0 read address.
// Depends on pgtw_pkg.
module pgtw_front #(
  parameter int PHYS_ADDR_BITS = 48
) (
  input  pgtw_pkg::pgtw_in_t        item_i,
  input  logic [pgtw_pkg::AddrW-1:0] low_base_i,
  input  logic [pgtw_pkg::AddrW-1:0] high_base_i,
  output pgtw_pkg::pgtw_cmd_t        cmd_o
);
  import pgtw_pkg::*;

  localparam logic [AddrW-1:0] PaMask = pa_mask(PHYS_ADDR_BITS);

  logic [AddrW-1:0] base;
  logic [AddrW-1:0] l0_addr;

  assign base    = (item_i.virt_addr[AddrW-1] ? high_base_i : low_base_i) & PaMask;
  assign l0_addr = base + {36'd0, item_i.virt_addr[47:39], 3'b000};

  always_comb begin
    cmd_o.vaddr = item_i.virt_addr;
    if (item_i.req_type == REQ_RESPONSE) begin
      cmd_o.kind = CMD_DESC;
      cmd_o.data = item_i.read_data;
    end else if (base == '0) begin
      cmd_o.kind = CMD_BASE_FAULT;
      cmd_o.data = '0;
    end else begin
      cmd_o.kind = CMD_WALK;
      cmd_o.data = {{(DescW-AddrW){1'b0}}, l0_addr};
    end
  end

endmodule

FILE: hdl/pgtw_queue.sv
// Short command queue between front and back end.
// Depends on pgtw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pgtw_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  pgtw_pkg::pgtw_cmd_t push_cmd_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output pgtw_pkg::pgtw_cmd_t head_o
);
  import pgtw_pkg::*;

  pgtw_cmd_t            slot_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] count_q, count_d;

  assign full_o  = (count_q == QueueCntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + QueueCntW'(push_i) - QueueCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  `PGTW_ASSERT(a_no_push_full, clk_i, rst_ni, push_i |-> !full_o)
  `PGTW_ASSERT(a_no_pop_empty, clk_i, rst_ni, pop_i |-> !empty_o)
  `PGTW_ASSERT_ALWAYS(a_count_bound, clk_i, !rst_ni || (count_q <= QueueCntW'(QueueDepth)))

endmodule

FILE: hdl/pgtw_back.sv
// Back end: walk state, descriptor checks and the result register.
// Depends on pgtw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pgtw_back #(
  parameter int PHYS_ADDR_BITS = 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  pgtw_pkg::pgtw_cmd_t cmd_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pgtw_pkg::pgtw_out_t out_item_o
);
  import pgtw_pkg::*;

  localparam logic [AddrW-1:0] PaMask = pa_mask(PHYS_ADDR_BITS);

  logic             busy_q, busy_d;
  logic [1:0]       level_q, level_d;
  logic [AddrW-1:0] vaddr_q, vaddr_d;
  logic             out_valid_q, out_valid_d;
  pgtw_out_t        out_q, out_d;

  logic             room;
  logic [1:0]       level_nxt;
  logic [8:0]       idx_nxt;
  logic [AddrW-1:0] desc_addr;

  assign room      = !out_valid_q || !out_stall_i;
  assign pop_o     = room && !empty_i;
  assign level_nxt = level_q + 2'd1;
  assign desc_addr = cmd_i.data[AddrW-1:0] & PaMask;

  always_comb begin
    unique case (level_nxt)
      2'd0: idx_nxt = vaddr_q[47:39];
      2'd1: idx_nxt = vaddr_q[38:30];
      2'd2: idx_nxt = vaddr_q[29:21];
      2'd3: idx_nxt = vaddr_q[20:12];
      default: idx_nxt = '0;
    endcase
  end

  always_comb begin
    busy_d      = busy_q;
    level_d     = level_q;
    vaddr_d     = vaddr_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (pop_o) begin
      unique case (cmd_i.kind)
        CMD_WALK: begin
          busy_d      = 1'b1;
          level_d     = 2'd0;
          vaddr_d     = cmd_i.vaddr;
          out_valid_d = 1'b1;
          out_d       = '{res_type: RES_READ, mem_addr: cmd_i.data[AddrW-1:0],
                          phys_addr: '0, fault: 1'b0, mapping_size: SIZE_4K};
        end
        CMD_BASE_FAULT: begin
          busy_d      = 1'b0;
          level_d     = 2'd0;
          vaddr_d     = cmd_i.vaddr;
          out_valid_d = 1'b1;
          out_d       = '{res_type: RES_DONE, mem_addr: '0, phys_addr: '0,
                          fault: 1'b1, mapping_size: SIZE_4K};
        end
        CMD_DESC: begin
          // responses while idle are dropped
          if (busy_q) begin
            out_valid_d = 1'b1;
            out_d       = '{res_type: RES_DONE, mem_addr: '0, phys_addr: '0,
                            fault: 1'b0, mapping_size: SIZE_4K};
            if (!cmd_i.data[DSC_VALID_BIT]) begin
              busy_d    = 1'b0;
              level_d   = 2'd0;
              out_d.fault = 1'b1;
            end else if (level_q == 2'd3) begin
              busy_d          = 1'b0;
              level_d         = 2'd0;
              out_d.phys_addr = {desc_addr[47:12], vaddr_q[11:0]};
            end else if (level_q == 2'd1 && !cmd_i.data[DSC_TABLE_BIT]) begin
              busy_d             = 1'b0;
              level_d            = 2'd0;
              out_d.phys_addr    = {desc_addr[47:30], vaddr_q[29:0]};
              out_d.mapping_size = SIZE_1G;
            end else if (level_q == 2'd2 && !cmd_i.data[DSC_TABLE_BIT]) begin
              busy_d             = 1'b0;
              level_d            = 2'd0;
              out_d.phys_addr    = {desc_addr[47:21], vaddr_q[20:0]};
              out_d.mapping_size = SIZE_2M;
            end else begin
              // table pointer: read the next level
              level_d        = level_nxt;
              out_d.res_type = RES_READ;
              out_d.mem_addr = desc_addr + {36'd0, idx_nxt, 3'b000};
            end
          end
        end
        default: begin
          busy_d = busy_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      level_q     <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      level_q     <= level_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vaddr_q <= vaddr_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `PGTW_ASSERT(a_level_needs_busy, clk_i, rst_ni, (level_q != 2'd0) |-> busy_q)
  `PGTW_ASSERT(a_read_is_clean, clk_i, rst_ni,
               (out_valid_q && out_q.res_type == RES_READ) |->
               (!out_q.fault && out_q.phys_addr == '0 && out_q.mem_addr[2:0] == 3'b000))
  `PGTW_ASSERT(a_read_keeps_busy, clk_i, rst_ni,
               ($rose(out_valid_q) && out_q.res_type == RES_READ) |-> busy_q)

endmodule

FILE: hdl/four_level_page_table_walker.sv
// Top level of the four-level page table walker (4KB granule, 48-bit VA).
// Depends on pgtw_pkg, pgtw_front, pgtw_queue and pgtw_back.
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_stall_o   in_item_i   (pgtw_in_t)
//   out       output     out_valid_o / out_stall_i out_item_o  (pgtw_out_t)
//   cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One item per cycle sustained while out is not stalled; an accepted item passes
// through the queue register, then the result register, before its result appears.
// Reset clears walk state, queue pointers and result valid; nothing to sweep.
// A stall on out holds the result register; the four-entry queue keeps taking
// items until it fills, and only then does in_stall_o rise.
module four_level_page_table_walker #(
  parameter int PHYS_ADDR_BITS = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  pgtw_pkg::pgtw_in_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output pgtw_pkg::pgtw_out_t           out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  pgtw_pkg::cfg_idx_e            cfg_index_i,
  input  logic [pgtw_pkg::AddrW-1:0]    cfg_data_i
);
  import pgtw_pkg::*;

  logic [AddrW-1:0] low_base_q;
  logic [AddrW-1:0] high_base_q;

  pgtw_cmd_t front_cmd;
  pgtw_cmd_t head_cmd;
  logic      q_full;
  logic      q_empty;
  logic      q_push;
  logic      q_pop;

  // Base registers; the user must write them only while the walker is quiet; the block has no check for it.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_base_q  <= '0;
      high_base_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_LOW_BASE:  low_base_q  <= cfg_data_i;
        CFG_HIGH_BASE: high_base_q <= cfg_data_i;
        default:       low_base_q  <= low_base_q;
      endcase
    end
  end

  assign in_stall_o = q_full;
  assign q_push     = in_valid_i && !q_full;

  pgtw_front #(
    .PHYS_ADDR_BITS(PHYS_ADDR_BITS)
  ) u_front (
    .item_i      (in_item_i),
    .low_base_i  (low_base_q),
    .high_base_i (high_base_q),
    .cmd_o       (front_cmd)
  );

  pgtw_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (front_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .head_o     (head_cmd)
  );

  pgtw_back #(
    .PHYS_ADDR_BITS(PHYS_ADDR_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .cmd_i       (head_cmd),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: tb/pgtw_walk_checker.sv
// Scoreboard for the four-level page table walker: watches the in, out and cfg channels.
// Predicts each result from its own copy of the walk state and the table bases.
// Depends on pgtw_pkg.
module pgtw_walk_checker
  import pgtw_pkg::*;
#(
  parameter int PHYS_ADDR_BITS = 48
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  pgtw_in_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  pgtw_out_t out_item_i,
  input  logic      cfg_valid_i,
  input  logic      cfg_ready_i,
  input  cfg_idx_e  cfg_index_i,
  input  logic [AddrW-1:0] cfg_data_i,
  output int        mismatches_o,
  output int        outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [AddrW-1:0] PageOfs  = 48'h0000_0000_0FFF;
  localparam logic [AddrW-1:0] MegaOfs  = 48'h0000_001F_FFFF;
  localparam logic [AddrW-1:0] GigaOfs  = 48'h0000_3FFF_FFFF;
  localparam logic [AddrW-1:0] TableMsk =
    ({AddrW{1'b1}} >> (AddrW - PHYS_ADDR_BITS)) & ~PageOfs;

  logic [AddrW-1:0] low_base, high_base;
  logic             walk_busy;
  logic [1:0]       walk_lvl;
  logic [AddrW-1:0] walk_va;

  pgtw_out_t expected_results[$];
  int        fail_cnt;

  assign mismatches_o  = fail_cnt;
  assign outstanding_o = expected_results.size();

  // 9-bit table index of the saved VA at the current level
  function automatic logic [8:0] level_index(logic [AddrW-1:0] va, logic [1:0] lvl);
    case (lvl)
      2'd0:    return va[47:39];
      2'd1:    return va[38:30];
      2'd2:    return va[29:21];
      default: return va[20:12];
    endcase
  endfunction

  // Advance the walk by one item; returns 1 when the item produces a result.
  function automatic bit walk_step(input pgtw_in_t it, output pgtw_out_t res);
    logic [AddrW-1:0] base;
    logic [AddrW-1:0] dsc_pa;
    res = '0;
    if (it.req_type == REQ_TRANSLATE) begin
      base     = it.virt_addr[AddrW-1] ? high_base : low_base;
      base     = base & TableMsk;
      walk_va  = it.virt_addr;
      walk_lvl = 2'd0;
      if (base == '0) begin
        walk_busy    = 1'b0;
        res.res_type = RES_DONE;
        res.fault    = 1'b1;
        return 1'b1;
      end
      walk_busy    = 1'b1;
      res.res_type = RES_READ;
      res.mem_addr = base + {level_index(walk_va, walk_lvl), 3'b000};
      return 1'b1;
    end
    if (!walk_busy) return 1'b0;

    dsc_pa       = it.read_data[AddrW-1:0] & TableMsk;
    res.res_type = RES_DONE;
    if (!it.read_data[DSC_VALID_BIT]) begin
      res.fault = 1'b1;
    end else if (walk_lvl == 2'd3) begin
      res.phys_addr    = dsc_pa | (walk_va & PageOfs);
      res.mapping_size = SIZE_4K;
    end else if (walk_lvl == 2'd1 && !it.read_data[DSC_TABLE_BIT]) begin
      res.phys_addr    = (dsc_pa & ~GigaOfs) | (walk_va & GigaOfs);
      res.mapping_size = SIZE_1G;
    end else if (walk_lvl == 2'd2 && !it.read_data[DSC_TABLE_BIT]) begin
      res.phys_addr    = (dsc_pa & ~MegaOfs) | (walk_va & MegaOfs);
      res.mapping_size = SIZE_2M;
    end else begin
      // table pointer (level 0 always): fetch the next level
      walk_lvl     = walk_lvl + 2'd1;
      res.res_type = RES_READ;
      res.mem_addr = dsc_pa + {level_index(walk_va, walk_lvl), 3'b000};
      return 1'b1;
    end
    walk_busy = 1'b0;
    walk_lvl  = 2'd0;
    return 1'b1;
  endfunction

  function automatic void check_field(string name, logic [AddrW-1:0] want,
                                      logic [AddrW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endfunction

  initial fail_cnt = 0;

  always @(posedge clk_i or negedge rst_ni) begin : track
    pgtw_out_t want;
    pgtw_out_t pred;
    if (!rst_ni) begin
      low_base  = '0;
      high_base = '0;
      walk_busy = 1'b0;
      walk_lvl  = 2'd0;
      walk_va   = '0;
      expected_results.delete();
    end else begin
      // results first: one accepted at this edge is always older than an item
      // accepted at the same edge
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: %p", out_item_i);
          fail_cnt++;
        end else begin
          want = expected_results.pop_front();
          check_field("res_type", AddrW'(want.res_type), AddrW'(out_item_i.res_type));
          check_field("mem_addr", want.mem_addr, out_item_i.mem_addr);
          check_field("phys_addr", want.phys_addr, out_item_i.phys_addr);
          check_field("fault", AddrW'(want.fault), AddrW'(out_item_i.fault));
          check_field("mapping_size", AddrW'(want.mapping_size),
                      AddrW'(out_item_i.mapping_size));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (walk_step(in_item_i, pred)) begin
          expected_results.insert(expected_results.size(), pred);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_LOW_BASE) low_base = cfg_data_i;
        else high_base = cfg_data_i;
      end
    end
  end

endmodule

FILE: tb/tb.sv
// Top of the page table walker testbench: clock, reset, stimulus and verdict.
// Drives directed and random walks with random idling on both channels.
// Depends on pgtw_pkg, four_level_page_table_walker and pgtw_walk_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pgtw_pkg::*;

  localparam int WatchdogLimit = 2000; // cycles with no handshake at all
  localparam int SettleCycles  = 8;    // queue plus result register, with margin
  localparam int PhaseItems    = 105;  // random items per base setting
  localparam int HoldCycles    = 60;   // long receiver hold-off, fills the queue
  localparam logic [AddrW-1:0] AllOnes = '1;
  localparam logic [AddrW-1:0] TopHalf = 48'h8000_0000_0000;

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  pgtw_in_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  pgtw_out_t out_item_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  cfg_idx_e  cfg_index_i = CFG_LOW_BASE;
  logic [AddrW-1:0] cfg_data_i = '0;

  int mismatches;
  int outstanding;
  int items_sent = 0;
  int idle_cycles = 0;
  bit hold_req = 1'b0;

  four_level_page_table_walker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  pgtw_walk_checker walk_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .in_item_i     (in_item_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_item_i    (out_item_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  // 50 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Item builders and random fields
  // ---------------------------------------------------------------------
  function automatic logic [AddrW-1:0] rand_addr();
    return AddrW'({$urandom, $urandom});
  endfunction

  function automatic logic [DescW-1:0] rand_desc();
    return {$urandom, $urandom};
  endfunction

  // Unused fields carry random bits so every payload bit toggles.
  function automatic pgtw_in_t xlate(logic [AddrW-1:0] va);
    pgtw_in_t it;
    it.req_type  = REQ_TRANSLATE;
    it.virt_addr = va;
    it.read_data = rand_desc();
    return it;
  endfunction

  function automatic pgtw_in_t resp(logic [DescW-1:0] dsc);
    pgtw_in_t it;
    it.req_type  = REQ_RESPONSE;
    it.virt_addr = rand_addr();
    it.read_data = dsc;
    return it;
  endfunction

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------
  // Hold the item until it is taken; valid is left high so the next item can
  // follow back to back.
  task automatic offer_item(input pgtw_in_t it);
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // Mostly no gap, sometimes a short one, rarely a long one.
  task automatic sender_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return;
    in_valid_i <= 1'b0;
    if (pick < 95) repeat ($urandom_range(1, 3)) @(posedge clk_i);
    else repeat ($urandom_range(8, 20)) @(posedge clk_i);
  endtask

  // Drop valid and let every expected result drain. Ignored responses leave no
  // result behind, so a few more cycles go by before the walker is idle.
  task automatic settle_walker();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write both level 0 table bases; valid stays up between the two writes.
  task automatic load_bases(input logic [AddrW-1:0] lo, input logic [AddrW-1:0] hi);
    cfg_index_i <= CFG_LOW_BASE;
    cfg_data_i  <= lo;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CFG_HIGH_BASE;
    cfg_data_i  <= hi;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // One walk: a translate request followed by the descriptors that lead it to
  // a chosen level and outcome. Some walks are cut short (the next request
  // aborts them) and some items are stray responses.
  task automatic drive_walk(input bit steady);
    int last_lvl;
    int cut_at;
    bit faulting;
    logic [DescW-1:0] dsc;
    if ($urandom_range(0, 9) == 0) begin
      offer_item(resp(rand_desc()));
      if (!steady) sender_gap();
      return;
    end
    offer_item(xlate(rand_addr()));
    if (!steady) sender_gap();
    last_lvl = $urandom_range(0, 3);
    faulting = ($urandom_range(0, 7) == 0);
    cut_at   = ($urandom_range(0, 11) == 0) ? $urandom_range(0, last_lvl) : last_lvl + 1;
    for (int lvl = 0; lvl <= last_lvl; lvl++) begin
      if (lvl == cut_at) break;
      dsc = rand_desc();
      if (lvl < last_lvl) dsc[1:0] = 2'b11;
      else if (faulting) dsc[DSC_VALID_BIT] = 1'b0;
      else if (lvl == 3) dsc[DSC_VALID_BIT] = 1'b1;
      else dsc[1:0] = 2'b01; // block at levels 1 and 2; at level 0 still a table
      offer_item(resp(dsc));
      if (!steady) sender_gap();
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver side: random stalls, calm stretches, and one long hold-off
  // ---------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    int gap_left;
    int calm_left;
    int pick;
    bit held;
    hold_left = 0;
    gap_left  = 0;
    calm_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_req && !held) begin
        held      = 1'b1;
        hold_left = HoldCycles - 1;
        out_stall_i <= 1'b1;
      end else if (gap_left != 0) begin
        gap_left--;
        out_stall_i <= 1'b1;
      end else if (calm_left != 0) begin
        calm_left--;
        out_stall_i <= 1'b0;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          calm_left = $urandom_range(20, 60);
          out_stall_i <= 1'b0;
        end else if (pick < 30) begin
          gap_left = (pick < 27) ? $urandom_range(0, 2) : $urandom_range(9, 24);
          out_stall_i <= 1'b1;
        end else begin
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog: ends the run when no channel moves for too long
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and verdict
  // ---------------------------------------------------------------------
  initial begin : stimulus
    logic [AddrW-1:0] lo_base;
    logic [AddrW-1:0] hi_base;
    int phase_start;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Both bases are zero out of reset: every request faults at once, and a
    // response with no walk running is dropped.
    offer_item(xlate('0));
    offer_item(xlate(AllOnes));
    offer_item(resp({DescW{1'b1}}));
    settle_walker();

    // Low base is only page-offset bits (zero once masked); high base is all ones.
    load_bases(48'h0000_0000_0FFF, AllOnes);
    offer_item(xlate('0));                      // masked-zero base faults
    offer_item(xlate(AllOnes));                 // highest descriptor address
    offer_item(resp({DescW{1'b1}}));            // level 0 table, upper bits dropped
    offer_item(resp(64'hFFFF_FFFF_FFFF_FFFD));  // level 1 block: 1GB
    offer_item(xlate(TopHalf));
    offer_item(resp(64'h0000_0000_0000_0003));  // table pointing at zero
    offer_item(resp(64'h0000_7FFF_FFFF_F003));
    offer_item(resp(64'hFFFF_8000_0000_0001));  // level 2 block: 2MB
    offer_item(xlate(TopHalf | 48'h0000_0000_0FFF));
    offer_item(resp(64'h0000_0000_0000_1001));  // level 0 ignores the table bit
    offer_item(resp(64'h0000_1234_5678_9003));
    offer_item(resp(64'h0000_ABCD_EF01_2003));
    offer_item(resp(64'hFFFF_FFFF_FFFF_FFFD));  // level 3 page, table bit clear
    offer_item(xlate(AllOnes));
    offer_item(resp(64'hFFFF_FFFF_FFFF_FFFE));  // invalid at level 0
    offer_item(xlate(AllOnes));
    offer_item(resp({DescW{1'b1}}));
    offer_item(xlate(TopHalf | 48'h0000_0000_0FFF)); // restart mid-walk
    offer_item(resp({DescW{1'b1}}));
    offer_item(resp(64'h0000_0000_0000_0002));  // invalid at level 1
    settle_walker();

    // Smallest nonzero low base, highest high base.
    load_bases(48'h0000_0000_1000, AllOnes);
    offer_item(xlate(48'h7FFF_FFFF_FFFF));
    offer_item(resp({DescW{1'b1}}));
    offer_item(resp({DescW{1'b1}}));
    offer_item(resp({DescW{1'b1}}));
    offer_item(resp(64'h0000_0000_0000_0000)); // invalid at level 3

    // Random walks across several base settings, extremes among them.
    for (int phase = 0; phase < 5; phase++) begin
      settle_walker();
      case (phase)
        0: begin lo_base = rand_addr();          hi_base = rand_addr(); end
        1: begin lo_base = AllOnes;              hi_base = '0;          end
        2: begin lo_base = '0;                   hi_base = rand_addr(); end
        3: begin lo_base = 48'h0000_0000_1000;   hi_base = AllOnes;     end
        default: begin lo_base = rand_addr();    hi_base = rand_addr(); end
      endcase
      load_bases(lo_base, hi_base);
      phase_start = items_sent;
      if (phase == 3) begin
        // receiver holds off while items keep coming back to back
        hold_req <= 1'b1;
        repeat (5) drive_walk(1'b1);
      end
      while (items_sent - phase_start < PhaseItems) drive_walk(1'b0);
    end

    settle_walker();
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
